// ===== rtl/tbm_pkg.sv =====
// Shared types, codes and the sequencer control store for the typed byte memory.
// Used by the top level and by its port checker; depends on nothing.
package tbm_pkg;

   localparam int MEM_BYTES_DEF = 64;
   localparam int CFG_W         = 7;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;

   localparam logic [CFG_W-1:0] SIZE_RESET = 7'd64;

   // register index decoded from csr address bit 2
   localparam logic REG_MEMORY_SIZE = 1'b0;

   localparam logic CMD_SET = 1'b0;
   localparam logic CMD_GET = 1'b1;

   localparam logic [1:0] KIND_STRING = 2'd0;
   localparam logic [1:0] KIND_WORD   = 2'd1;
   localparam logic [1:0] KIND_HALF   = 2'd2;
   localparam logic [1:0] KIND_BYTE   = 2'd3;

   localparam logic [1:0] RES_NUM   = 2'd0;
   localparam logic [1:0] RES_CHAR  = 2'd1;
   localparam logic [1:0] RES_EMPTY = 2'd2;
   localparam logic [1:0] RES_VIOL  = 2'd3;

   typedef struct packed {
      logic               command;
      logic [1:0]         data_kind;
      logic signed [15:0] position;
      logic [31:0]        write_value;
      logic               char_present;
      logic               string_last;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [31:0] read_value;
      logic        last_result;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      STEP_IDLE  = 4'd0,
      STEP_STR   = 4'd1,
      STEP_VIOL  = 4'd2,
      STEP_NSET  = 4'd3,
      STEP_NCHK  = 4'd4,
      STEP_NGET0 = 4'd5,
      STEP_NGET  = 4'd6,
      STEP_NOUT  = 4'd7,
      STEP_SGRD  = 4'd8,
      STEP_SGDAT = 4'd9,
      STEP_SGCH  = 4'd10,
      STEP_SGEND = 4'd11
   } step_type;

   typedef enum logic [3:0] {
      ACT_ACCEPT,
      ACT_STR_ITEM,
      ACT_WR_BYTE,
      ACT_RD_FIRST,
      ACT_RD_COLLECT,
      ACT_EMIT_VIOL,
      ACT_EMIT_NUM,
      ACT_SG_READ,
      ACT_SG_CHAR,
      ACT_SG_END,
      ACT_NONE
   } act_type;

   typedef enum logic [3:0] {
      COND_ALWAYS,
      COND_DISPATCH,
      COND_STR_VIOL,
      COND_LANE_DONE,
      COND_OVER,
      COND_OUT_FREE,
      COND_IN_RANGE,
      COND_BYTE_ZERO,
      COND_CHAR_DONE
   } cond_type;

   typedef struct packed {
      act_type  act;
      cond_type cond;
      step_type tgt_t;
      step_type tgt_f;
   } uword_type;

   // control store: action, jump condition, target when true, target when false
   function automatic uword_type ucode(step_type s);
      uword_type w;
      unique case (s)
         STEP_IDLE:  w = '{ACT_ACCEPT,     COND_DISPATCH,  STEP_IDLE,  STEP_IDLE};
         STEP_STR:   w = '{ACT_STR_ITEM,   COND_STR_VIOL,  STEP_VIOL,  STEP_IDLE};
         STEP_VIOL:  w = '{ACT_EMIT_VIOL,  COND_OUT_FREE,  STEP_IDLE,  STEP_VIOL};
         STEP_NSET:  w = '{ACT_WR_BYTE,    COND_LANE_DONE, STEP_NCHK,  STEP_NSET};
         STEP_NCHK:  w = '{ACT_NONE,       COND_OVER,      STEP_VIOL,  STEP_IDLE};
         STEP_NGET0: w = '{ACT_RD_FIRST,   COND_ALWAYS,    STEP_NGET,  STEP_NGET};
         STEP_NGET:  w = '{ACT_RD_COLLECT, COND_LANE_DONE, STEP_NOUT,  STEP_NGET};
         STEP_NOUT:  w = '{ACT_EMIT_NUM,   COND_OUT_FREE,  STEP_IDLE,  STEP_NOUT};
         STEP_SGRD:  w = '{ACT_SG_READ,    COND_IN_RANGE,  STEP_SGDAT, STEP_SGEND};
         STEP_SGDAT: w = '{ACT_NONE,       COND_BYTE_ZERO, STEP_SGEND, STEP_SGCH};
         STEP_SGCH:  w = '{ACT_SG_CHAR,    COND_CHAR_DONE, STEP_SGRD,  STEP_SGCH};
         STEP_SGEND: w = '{ACT_SG_END,     COND_OUT_FREE,  STEP_IDLE,  STEP_SGEND};
         default:    w = '{ACT_ACCEPT,     COND_DISPATCH,  STEP_IDLE,  STEP_IDLE};
      endcase
      return w;
   endfunction

   // index of the last byte lane of a numeric access
   function automatic logic [1:0] last_lane(logic [1:0] kind);
      logic [1:0] n;
      case (kind)
         KIND_WORD: n = 2'd3;
         KIND_HALF: n = 2'd1;
         default:   n = 2'd0;
      endcase
      return n;
   endfunction

endpackage

// ===== rtl/typed_byte_memory_with_bounds_check.sv =====
// Typed byte memory with bounds check: top level, microcoded sequencer and datapath.
// Depends on tbm_pkg for payload types, codes and the control store.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    req_payload (tbm_pkg::req_payload_type)
//   rsp      out        rsp_valid/stall    rsp_payload (tbm_pkg::rsp_payload_type)
//   csr      in/out     APB-style write    memory_size at byte address 0
//
// One transaction at a time; the single-port byte store with a registered read sets the pace.
// String set item: STEP_STR, then STEP_VIOL with a violation result. Numeric set: STEP_NSET per lane,
// then STEP_NCHK, then STEP_VIOL on violation. Numeric get: STEP_NGET0, STEP_NGET per lane, STEP_NOUT;
// STEP_VIOL alone when out of bounds. String get: STEP_SGRD, STEP_SGDAT, STEP_SGCH per character, then STEP_SGEND.
// Reset clears the store at once through per-byte valid bits; no clearing pass.
// A stalled result waits in the output register; the next transaction is taken meanwhile.
module typed_byte_memory_with_bounds_check #(
   parameter int MEM_BYTES = tbm_pkg::MEM_BYTES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  tbm_pkg::req_payload_type         req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output tbm_pkg::rsp_payload_type         rsp_payload,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [tbm_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [tbm_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [tbm_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);

   localparam int IDX_W = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;
   localparam logic [tbm_pkg::CFG_W-1:0] MEM_LIMIT = tbm_pkg::CFG_W'(MEM_BYTES);

   tbm_pkg::step_type        pc_ff, pc_in;
   tbm_pkg::uword_type       uw;
   tbm_pkg::step_type        disp_step;

   logic [tbm_pkg::CFG_W-1:0] cfg_size_ff;
   logic [tbm_pkg::CFG_W-1:0] sz;

   logic [15:0] addr_ff, addr_in;
   logic [1:0]  lane_ff, lane_in;
   logic [1:0]  nlast_ff, nlast_in;
   logic        over_ff, over_in;
   logic [31:0] value_ff, value_in;
   logic        cp_ff, cp_in;
   logic        last_ff, last_in;
   logic        str_active_ff, str_active_in;
   logic [15:0] str_start_ff, str_start_in;
   logic [15:0] str_len_ff, str_len_in;
   logic        str_neg_ff, str_neg_in;
   logic [7:0]  pend_ff, pend_in;
   logic        pend_vld_ff, pend_vld_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   tbm_pkg::rsp_payload_type rsp_payload_ff, rsp_payload_in;
   logic                     out_load;
   tbm_pkg::rsp_payload_type out_data;

   logic [7:0]           mem_ram [MEM_BYTES];
   logic [MEM_BYTES-1:0] vb_ff;
   logic                 mem_we, mem_re;
   logic [IDX_W-1:0]     mem_waddr;
   logic [7:0]           mem_wdata;
   logic [7:0]           rd_data_ff;
   logic                 rd_vld_ff;

   logic        req_accept, cfg_write;
   logic        out_free, in_range, lane_done, cond_ok;
   logic [7:0]  rd_byte;
   logic [15:0] pos_bits;
   logic        pos_neg, str_take, in_over;
   logic [1:0]  in_nlast;
   logic [16:0] str_addr, str_end;
   logic [15:0] str_len_nx;
   logic        str_viol;

   // ---------------------------------------------------------------- config
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == tbm_pkg::REG_MEMORY_SIZE)
                       ? {{(tbm_pkg::CSR_DATA_W-tbm_pkg::CFG_W){1'b0}}, cfg_size_ff}
                       : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_size_ff <= tbm_pkg::SIZE_RESET;
      end else if (cfg_write && csr_paddr[2] == tbm_pkg::REG_MEMORY_SIZE) begin
         cfg_size_ff <= csr_pwdata[tbm_pkg::CFG_W-1:0];
      end
   end

   assign sz = (cfg_size_ff > MEM_LIMIT) ? MEM_LIMIT : cfg_size_ff;

   // ---------------------------------------------------------------- store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ram[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem_ram[addr_ff[IDX_W-1:0]];
         rd_vld_ff  <= vb_ff[addr_ff[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= '0;
      end else if (mem_we) begin
         vb_ff[mem_waddr] <= 1'b1;
      end
   end

   // a byte never written reads as zero
   assign rd_byte = rd_vld_ff ? rd_data_ff : 8'h00;

   // ---------------------------------------------------------------- decode
   assign uw         = tbm_pkg::ucode(pc_ff);
   assign req_stall  = (uw.act != tbm_pkg::ACT_ACCEPT);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign in_range   = addr_ff < {9'b0, sz};
   assign lane_done  = (lane_ff == nlast_ff);

   assign pos_bits = req_payload.position;
   assign pos_neg  = pos_bits[15];
   assign in_nlast = tbm_pkg::last_lane(req_payload.data_kind);
   assign in_over  = ({1'b0, pos_bits} + {15'b0, in_nlast} + 17'd1) > {10'b0, sz};
   assign str_take = str_active_ff ||
                     (req_payload.command == tbm_pkg::CMD_SET &&
                      req_payload.data_kind == tbm_pkg::KIND_STRING);

   assign str_addr   = {1'b0, str_start_ff} + {1'b0, str_len_ff};
   assign str_len_nx = (cp_ff && str_len_ff != 16'hFFFF) ? str_len_ff + 16'd1 : str_len_ff;
   assign str_end    = {1'b0, str_start_ff} + {1'b0, str_len_nx};
   assign str_viol   = str_neg_ff || (str_end >= {10'b0, sz});

   always_comb begin
      if (str_take) begin
         disp_step = tbm_pkg::STEP_STR;
      end else if (pos_neg) begin
         disp_step = tbm_pkg::STEP_VIOL;
      end else if (req_payload.data_kind == tbm_pkg::KIND_STRING) begin
         disp_step = tbm_pkg::STEP_SGRD;
      end else if (req_payload.command == tbm_pkg::CMD_SET) begin
         disp_step = tbm_pkg::STEP_NSET;
      end else if (in_over) begin
         disp_step = tbm_pkg::STEP_VIOL;
      end else begin
         disp_step = tbm_pkg::STEP_NGET0;
      end
   end

   // ---------------------------------------------------------------- sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= tbm_pkg::STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   always_comb begin
      unique case (uw.cond)
         tbm_pkg::COND_ALWAYS:    cond_ok = 1'b1;
         tbm_pkg::COND_DISPATCH:  cond_ok = req_accept;
         tbm_pkg::COND_STR_VIOL:  cond_ok = last_ff && str_viol;
         tbm_pkg::COND_LANE_DONE: cond_ok = lane_done;
         tbm_pkg::COND_OVER:      cond_ok = over_ff;
         tbm_pkg::COND_OUT_FREE:  cond_ok = out_free;
         tbm_pkg::COND_IN_RANGE:  cond_ok = in_range;
         tbm_pkg::COND_BYTE_ZERO: cond_ok = (rd_byte == 8'h00);
         tbm_pkg::COND_CHAR_DONE: cond_ok = !pend_vld_ff || out_free;
         default:                 cond_ok = 1'b0;
      endcase

      if (cond_ok) begin
         pc_in = (uw.cond == tbm_pkg::COND_DISPATCH) ? disp_step : uw.tgt_t;
      end else begin
         pc_in = uw.tgt_f;
      end
   end

   // ---------------------------------------------------------------- datapath
   always_comb begin
      addr_in       = addr_ff;
      lane_in       = lane_ff;
      nlast_in      = nlast_ff;
      over_in       = over_ff;
      value_in      = value_ff;
      cp_in         = cp_ff;
      last_in       = last_ff;
      str_active_in = str_active_ff;
      str_start_in  = str_start_ff;
      str_len_in    = str_len_ff;
      str_neg_in    = str_neg_ff;
      pend_in       = pend_ff;
      pend_vld_in   = pend_vld_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_waddr     = addr_ff[IDX_W-1:0];
      mem_wdata     = value_ff[7:0];
      out_load      = 1'b0;
      out_data      = '{tbm_pkg::RES_VIOL, 32'd0, 1'b1};

      unique case (uw.act)
         tbm_pkg::ACT_ACCEPT: begin
            if (req_accept) begin
               addr_in     = pos_bits;
               lane_in     = 2'd0;
               nlast_in    = in_nlast;
               over_in     = in_over;
               // string items keep their character whatever their command
               value_in    = (req_payload.command == tbm_pkg::CMD_SET || str_take)
                             ? req_payload.write_value : 32'd0;
               cp_in       = req_payload.char_present;
               last_in     = req_payload.string_last;
               pend_vld_in = 1'b0;
               // first item of a string set opens it
               if (str_take && !str_active_ff) begin
                  str_active_in = 1'b1;
                  str_neg_in    = pos_neg;
                  str_start_in  = pos_neg ? 16'd0 : pos_bits;
                  str_len_in    = 16'd0;
               end
            end
         end
         tbm_pkg::ACT_STR_ITEM: begin
            if (cp_ff && !str_neg_ff && str_addr < {10'b0, sz}) begin
               mem_we    = 1'b1;
               mem_waddr = str_addr[IDX_W-1:0];
               mem_wdata = value_ff[7:0];
            end
            str_len_in = str_len_nx;
            if (last_ff) begin
               str_active_in = 1'b0;
            end
         end
         tbm_pkg::ACT_WR_BYTE: begin
            // store only the lanes below the end
            if (in_range) begin
               mem_we    = 1'b1;
               mem_wdata = value_ff[8*lane_ff +: 8];
            end
            if (!lane_done) begin
               addr_in = addr_ff + 16'd1;
               lane_in = lane_ff + 2'd1;
            end
         end
         tbm_pkg::ACT_RD_FIRST: begin
            mem_re  = 1'b1;
            addr_in = addr_ff + 16'd1;
         end
         tbm_pkg::ACT_RD_COLLECT: begin
            value_in[8*lane_ff +: 8] = rd_byte;
            if (!lane_done) begin
               mem_re  = 1'b1;
               addr_in = addr_ff + 16'd1;
               lane_in = lane_ff + 2'd1;
            end
         end
         tbm_pkg::ACT_EMIT_VIOL: begin
            out_load = out_free;
            out_data = '{tbm_pkg::RES_VIOL, 32'd0, 1'b1};
         end
         tbm_pkg::ACT_EMIT_NUM: begin
            out_load = out_free;
            out_data = '{tbm_pkg::RES_NUM, value_ff, 1'b1};
         end
         tbm_pkg::ACT_SG_READ: begin
            if (in_range) begin
               mem_re  = 1'b1;
               addr_in = addr_ff + 16'd1;
            end
         end
         tbm_pkg::ACT_SG_CHAR: begin
            // hold one character back until the next byte tells whether it is last
            if (pend_vld_ff) begin
               if (out_free) begin
                  out_load = 1'b1;
                  out_data = '{tbm_pkg::RES_CHAR, {24'd0, pend_ff}, 1'b0};
                  pend_in  = rd_byte;
               end
            end else begin
               pend_in     = rd_byte;
               pend_vld_in = 1'b1;
            end
         end
         tbm_pkg::ACT_SG_END: begin
            out_load = out_free;
            out_data = pend_vld_ff ? '{tbm_pkg::RES_CHAR, {24'd0, pend_ff}, 1'b1}
                                   : '{tbm_pkg::RES_EMPTY, 32'd0, 1'b1};
         end
         tbm_pkg::ACT_NONE: begin
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      if (out_load) begin
         rsp_valid_in   = 1'b1;
         rsp_payload_in = out_data;
      end else begin
         rsp_valid_in   = rsp_valid_ff && rsp_stall;
         rsp_payload_in = rsp_payload_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         str_active_ff <= 1'b0;
         str_start_ff  <= 16'd0;
         str_len_ff    <= 16'd0;
         str_neg_ff    <= 1'b0;
         pend_vld_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         str_active_ff <= str_active_in;
         str_start_ff  <= str_start_in;
         str_len_ff    <= str_len_in;
         str_neg_ff    <= str_neg_in;
         pend_vld_ff   <= pend_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff        <= addr_in;
      lane_ff        <= lane_in;
      nlast_ff       <= nlast_in;
      over_ff        <= over_in;
      value_ff       <= value_in;
      cp_ff          <= cp_in;
      last_ff        <= last_in;
      pend_ff        <= pend_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// ===== rtl/tbm_checker.sv =====
// Port-level checks for the typed byte memory, attached to the top level by bind.
// Depends on tbm_pkg for payload types and result codes.
module tbm_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input tbm_pkg::rsp_payload_type       rsp_payload,
   input logic [tbm_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input logic [tbm_pkg::CSR_DATA_W-1:0] csr_prdata
);

   // a waiting result is not withdrawn
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   // violations and empty strings close their transaction with no value
   a_viol_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.result_kind == tbm_pkg::RES_VIOL ||
                    rsp_payload.result_kind == tbm_pkg::RES_EMPTY)
      |-> rsp_payload.last_result && rsp_payload.read_value == 32'd0)
      else $error("violation or empty result malformed");

   // a string character is a single nonzero byte
   a_char_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.result_kind == tbm_pkg::RES_CHAR
      |-> rsp_payload.read_value[31:8] == 24'd0 && rsp_payload.read_value[7:0] != 8'd0)
      else $error("string character out of range");

   // size register comes out of reset at its default
   a_size_reset: assert property (@(posedge clock)
      $past(reset) && !reset && csr_paddr[2] == tbm_pkg::REG_MEMORY_SIZE
      |-> csr_prdata == {{(tbm_pkg::CSR_DATA_W-tbm_pkg::CFG_W){1'b0}}, tbm_pkg::SIZE_RESET})
      else $error("memory_size wrong after reset");

endmodule

bind typed_byte_memory_with_bounds_check tbm_checker u_tbm_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload),
   .csr_paddr   (csr_paddr),
   .csr_prdata  (csr_prdata)
);

// ===== sim/tbm_result_checker.sv =====
// Scoreboard for the typed byte memory: watches the request, result and register ports,
// predicts every result from its own copy of the store and compares them in order.
// Depends on tbm_pkg for the payload types, command, kind and result codes.
module tbm_result_checker #(
   parameter int MEM_BYTES = tbm_pkg::MEM_BYTES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  tbm_pkg::req_payload_type       req_payload,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  tbm_pkg::rsp_payload_type       rsp_payload,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [tbm_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [tbm_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  logic                           csr_pready,
   output int                             fail_count,
   output int                             outstanding,
   output int                             results_seen
);

   logic [7:0]                mirror [MEM_BYTES];
   logic [tbm_pkg::CFG_W-1:0] size_reg;
   logic                      str_open;
   logic                      str_below_zero;
   int unsigned               str_base;
   int unsigned               str_count;
   tbm_pkg::rsp_payload_type  awaited [$];
   int                        fails = 0;
   int                        owed = 0;
   int                        seen = 0;

   assign fail_count   = fails;
   assign outstanding  = owed;
   assign results_seen = seen;

   function automatic void add_result(logic [1:0] k, logic [31:0] v, logic fin);
      tbm_pkg::rsp_payload_type r;
      r.result_kind = k;
      r.read_value  = v;
      r.last_result = fin;
      awaited.push_back(r);
   endfunction

   function automatic void predict_access(tbm_pkg::req_payload_type t);
      int unsigned span;
      int unsigned pos;
      int unsigned width;
      int unsigned stop;
      int unsigned at;
      logic        neg;
      logic [31:0] word;
      span = (size_reg > MEM_BYTES) ? MEM_BYTES : size_reg;
      pos  = t.position[15:0];
      neg  = t.position[15];
      word = '0;
      if (str_open || (t.command == tbm_pkg::CMD_SET && t.data_kind == tbm_pkg::KIND_STRING))
      begin
         // the first item of a string fixes where it goes
         if (!str_open) begin
            str_open       = 1'b1;
            str_below_zero = neg;
            str_base       = neg ? 0 : pos;
            str_count      = 0;
         end
         if (t.char_present) begin
            at = str_base + str_count;
            if (!str_below_zero && at < span)
               mirror[at] = t.write_value[7:0];
            if (str_count < 65535)
               str_count++;
         end
         if (t.string_last) begin
            str_open = 1'b0;
            if (str_below_zero || str_base + str_count >= span)
               add_result(tbm_pkg::RES_VIOL, '0, 1'b1);
         end
      end else if (neg) begin
         add_result(tbm_pkg::RES_VIOL, '0, 1'b1);
      end else if (t.data_kind == tbm_pkg::KIND_STRING) begin
         // walk to a zero byte or the end of the store in use
         stop = pos;
         while (stop < span && mirror[stop] != 8'h00)
            stop++;
         if (stop == pos)
            add_result(tbm_pkg::RES_EMPTY, '0, 1'b1);
         for (at = pos; at < stop; at++)
            add_result(tbm_pkg::RES_CHAR, 32'(mirror[at]), at + 1 == stop);
      end else begin
         width = (t.data_kind == tbm_pkg::KIND_WORD) ? 4 :
                 (t.data_kind == tbm_pkg::KIND_HALF) ? 2 : 1;
         if (t.command == tbm_pkg::CMD_SET) begin
            // drop only the bytes at or past the end
            for (int i = 0; i < width; i++)
               if (pos + i < span)
                  mirror[pos + i] = t.write_value[8*i +: 8];
         end else if (pos + width <= span) begin
            for (int i = 0; i < width; i++)
               word[8*i +: 8] = mirror[pos + i];
         end
         if (pos + width > span)
            add_result(tbm_pkg::RES_VIOL, '0, 1'b1);
         else if (t.command == tbm_pkg::CMD_GET)
            add_result(tbm_pkg::RES_NUM, word, 1'b1);
      end
   endfunction

   function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         fails++;
      end
   endfunction

   function automatic void check_result(tbm_pkg::rsp_payload_type got);
      tbm_pkg::rsp_payload_type want;
      seen++;
      if (awaited.size() == 0) begin
         $display("%0t: unexpected result, expected none, actual kind %0d value %0h last %0b",
                  $time, got.result_kind, got.read_value, got.last_result);
         fails++;
      end else begin
         want = awaited.pop_front();
         compare_field("result_kind", 32'(want.result_kind), 32'(got.result_kind));
         compare_field("read_value", want.read_value, got.read_value);
         compare_field("last_result", 32'(want.last_result), 32'(got.last_result));
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MEM_BYTES; i++)
            mirror[i] = 8'h00;
         size_reg       = tbm_pkg::SIZE_RESET;
         str_open       = 1'b0;
         str_below_zero = 1'b0;
         str_base       = 0;
         str_count      = 0;
         awaited.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
             && csr_paddr[2] == tbm_pkg::REG_MEMORY_SIZE)
            size_reg = csr_pwdata[tbm_pkg::CFG_W-1:0];
         if (req_valid && !req_stall)
            predict_access(req_payload);
         if (rsp_valid && !rsp_stall)
            check_result(rsp_payload);
      end
      owed = awaited.size();
   end

endmodule

// ===== sim/tb_typed_byte_memory_with_bounds_check.sv =====
// Testbench top for the typed byte memory: clock, reset, request and register stimulus,
// result-side stalls, watchdog and verdict. Depends on tbm_pkg, the block and tbm_result_checker.
module tb_typed_byte_memory_with_bounds_check;

   localparam int MEM_BYTES      = tbm_pkg::MEM_BYTES_DEF;
   localparam int SETTLE_CYCLES  = 20;
   localparam int LONG_HOLD      = 200;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SEG_ITEMS      = 22;
   localparam logic [tbm_pkg::CSR_ADDR_W-1:0] SIZE_ADDR = {tbm_pkg::REG_MEMORY_SIZE, 2'b00};

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_stall;
   tbm_pkg::req_payload_type       req_payload;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   tbm_pkg::rsp_payload_type       rsp_payload;
   logic                           csr_psel;
   logic                           csr_penable;
   logic                           csr_pwrite;
   logic [tbm_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [tbm_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [tbm_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   int          mismatch_total;
   int          results_owed;
   int          results_checked;
   int          items_sent = 0;
   int          sizes_used = 0;
   int unsigned size_span = MEM_BYTES;
   int unsigned send_gap_pct = 0;
   int unsigned recv_stall_pct = 0;
   int          holds_requested = 0;
   int          holds_served = 0;
   int          hold_left = 0;
   int          quiet_cycles = 0;

   typed_byte_memory_with_bounds_check #(.MEM_BYTES(MEM_BYTES)) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   tbm_result_checker #(.MEM_BYTES(MEM_BYTES)) i_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_pready   (csr_pready),
      .fail_count   (mismatch_total),
      .outstanding  (results_owed),
      .results_seen (results_checked)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // result side: random stalls, or a long hold-off when one is requested
   always @(negedge clock) begin
      if (holds_served != holds_requested) begin
         holds_served = holds_requested;
         hold_left    = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_item(input tbm_pkg::req_payload_type t);
      @(negedge clock);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= t;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic send_fields(input logic cmd, input logic [1:0] kind, input logic [15:0] pos,
                              input logic [31:0] val, input logic cp, input logic fin);
      tbm_pkg::req_payload_type t;
      t.command      = cmd;
      t.data_kind    = kind;
      t.position     = pos;
      t.write_value  = val;
      t.char_present = cp;
      t.string_last  = fin;
      send_item(t);
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (results_owed != 0)
         @(negedge clock);
   endtask

   task automatic drain_and_settle();
      wait_for_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_size(input logic [tbm_pkg::CFG_W-1:0] v);
      @(negedge clock);
      csr_paddr   <= SIZE_ADDR;
      csr_pwdata  <= {{(tbm_pkg::CSR_DATA_W-tbm_pkg::CFG_W){1'b0}}, v};
      csr_pwrite  <= 1'b1;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      size_span = (v > MEM_BYTES) ? MEM_BYTES : v;
      sizes_used++;
   endtask

   function automatic logic [15:0] random_position();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 6)
         return {1'b1, 15'($urandom)};
      if (r < 10)
         return 16'($urandom);
      // aim at the end of the store in use
      if (r < 40)
         return 16'(size_span + 2 - $urandom_range(6));
      return 16'($urandom_range(size_span + 3));
   endfunction

   function automatic logic [7:0] random_char();
      return ($urandom_range(9) == 0) ? 8'h00 : 8'($urandom_range(255, 1));
   endfunction

   function automatic tbm_pkg::req_payload_type random_item();
      tbm_pkg::req_payload_type t;
      t.command      = 1'($urandom);
      t.data_kind    = 2'($urandom);
      t.position     = random_position();
      t.write_value  = $urandom;
      t.char_present = 1'($urandom);
      t.string_last  = 1'($urandom);
      return t;
   endfunction

   task automatic send_random_access();
      tbm_pkg::req_payload_type t;
      int unsigned              pick;
      int unsigned              len;
      pick = $urandom_range(99);
      t    = random_item();
      if (pick < 25) begin
         // whole string set; inner items carry arbitrary command, kind and position
         len = ($urandom_range(3) == 0) ? $urandom_range(20) : $urandom_range(5);
         t.command          = tbm_pkg::CMD_SET;
         t.data_kind        = tbm_pkg::KIND_STRING;
         t.char_present     = (len != 0);
         t.string_last      = (len <= 1);
         t.write_value[7:0] = random_char();
         send_item(t);
         for (int i = 1; i < len; i++) begin
            t = random_item();
            t.char_present     = (i == len - 1) || ($urandom_range(9) != 0);
            t.string_last      = (i == len - 1);
            t.write_value[7:0] = random_char();
            send_item(t);
         end
      end else if (pick < 30) begin
         // open a string and leave it to whatever traffic follows
         t.command     = tbm_pkg::CMD_SET;
         t.data_kind   = tbm_pkg::KIND_STRING;
         t.string_last = 1'b0;
         send_item(t);
      end else if (pick < 35) begin
         send_item(t);
      end else if (pick < 55) begin
         t.command   = tbm_pkg::CMD_GET;
         t.data_kind = tbm_pkg::KIND_STRING;
         send_item(t);
      end else begin
         t.data_kind = 2'($urandom_range(3, 1));
         send_item(t);
      end
   endtask

   initial begin
      logic [tbm_pkg::CFG_W-1:0] seg_size [6];
      int                        goal;
      logic                      paused;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      paused      = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_size(7'd16);
      send_fields(tbm_pkg::CMD_SET, tbm_pkg::KIND_WORD, 16'd0, 32'h8040_2001, 1'b0, 1'b0);
      send_fields(tbm_pkg::CMD_GET, tbm_pkg::KIND_WORD, 16'd0, 32'h0, 1'b0, 1'b0);
      send_fields(tbm_pkg::CMD_GET, tbm_pkg::KIND_HALF, 16'd1, 32'h0, 1'b0, 1'b0);
      send_fields(tbm_pkg::CMD_GET, tbm_pkg::KIND_BYTE, 16'd3, 32'h0, 1'b0, 1'b0);
      send_fields(tbm_pkg::CMD_SET, tbm_pkg::KIND_WORD, 16'd14, 32'hFFFF_FFFF, 1'b1, 1'b1);
      send_fields(tbm_pkg::CMD_GET, tbm_pkg::KIND_HALF, 16'd14, 32'h0, 1'b0, 1'b0);
      send_fields(tbm_pkg::CMD_SET, tbm_pkg::KIND_BYTE, 16'h8000, 32'hFFFF_FFFF, 1'b0, 1'b0);
      send_fields(tbm_pkg::CMD_GET, tbm_pkg::KIND_WORD, 16'h7FFF, 32'h0, 1'b1, 1'b1);
      send_fields(tbm_pkg::CMD_SET, tbm_pkg::KIND_HALF, 16'd15, 32'h0000_5AA5, 1'b0, 1'b0);
      send_fields(tbm_pkg::CMD_SET, tbm_pkg::KIND_BYTE, 16'd7, 32'h1234_5678, 1'b0, 1'b0);
      send_fields(tbm_pkg::CMD_GET, tbm_pkg::KIND_STRING, 16'd0, 32'h0, 1'b0, 1'b0);
      send_fields(tbm_pkg::CMD_GET, tbm_pkg::KIND_STRING, 16'd16, 32'h0, 1'b0, 1'b0);
      send_fields(tbm_pkg::CMD_GET, tbm_pkg::KIND_STRING, 16'd14, 32'h0, 1'b0, 1'b0);
      // second item looks like a word get but belongs to the string
      send_fields(tbm_pkg::CMD_SET, tbm_pkg::KIND_STRING, 16'd4, 32'h41, 1'b1, 1'b0);
      send_fields(tbm_pkg::CMD_GET, tbm_pkg::KIND_WORD, 16'hFFFF, 32'h42, 1'b1, 1'b1);
      send_fields(tbm_pkg::CMD_SET, tbm_pkg::KIND_STRING, 16'd8, 32'h0, 1'b0, 1'b1);
      send_fields(tbm_pkg::CMD_SET, tbm_pkg::KIND_STRING, 16'd14, 32'h78, 1'b1, 1'b0);
      send_fields(tbm_pkg::CMD_SET, tbm_pkg::KIND_STRING, 16'd0, 32'h79, 1'b1, 1'b1);
      send_fields(tbm_pkg::CMD_SET, tbm_pkg::KIND_STRING, -16'sd5, 32'h7A, 1'b1, 1'b1);
      send_fields(tbm_pkg::CMD_GET, tbm_pkg::KIND_STRING, 16'd4, 32'h0, 1'b0, 1'b0);
      drain_and_settle();
      write_size(7'd0);
      send_fields(tbm_pkg::CMD_SET, tbm_pkg::KIND_BYTE, 16'd0, 32'hA5, 1'b0, 1'b0);
      send_fields(tbm_pkg::CMD_GET, tbm_pkg::KIND_STRING, 16'd0, 32'h0, 1'b0, 1'b0);
      send_fields(tbm_pkg::CMD_SET, tbm_pkg::KIND_STRING, 16'd0, 32'h0, 1'b0, 1'b1);
      drain_and_settle();
      write_size(7'd127);
      send_fields(tbm_pkg::CMD_GET, tbm_pkg::KIND_WORD, 16'd60, 32'h0, 1'b0, 1'b0);
      send_fields(tbm_pkg::CMD_SET, tbm_pkg::KIND_WORD, 16'd62, 32'hC3C3_3C3C, 1'b0, 1'b0);

      seg_size = '{7'd64, 7'd1, 7'($urandom_range(63, 2)), 7'd127,
                   7'($urandom_range(64, 1)), 7'd64};
      for (int seg = 0; seg < 6; seg++) begin
         drain_and_settle();
         write_size(seg_size[seg]);
         case (seg / 2)
            0: begin
               send_gap_pct   = 34;
               recv_stall_pct = 47;
            end
            1: begin
               send_gap_pct   = 47;
               recv_stall_pct = 34;
            end
            default: begin
               send_gap_pct   = 0;
               recv_stall_pct = 0;
            end
         endcase
         // hold the result side off while requests keep coming
         if (seg == 4)
            holds_requested++;
         goal = items_sent + SEG_ITEMS;
         while (items_sent < goal) begin
            send_random_access();
            if (seg == 1 && !paused && items_sent >= goal - SEG_ITEMS / 2) begin
               paused = 1'b1;
               wait_for_results();
            end
         end
      end
      drain_and_settle();

      $display("Covered %0d request and %0d result transactions over %0d memory sizes",
               items_sent, results_checked, sizes_used);
      if (mismatch_total == 0 && results_owed == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/tbm_pkg.sv
rtl/typed_byte_memory_with_bounds_check.sv
rtl/tbm_checker.sv
sim/tbm_result_checker.sv
sim/tb_typed_byte_memory_with_bounds_check.sv
